// ----- hw/rtl/riscv_csr_register_file_macros.svh -----
// Assertion macros used by the CSR file checker.
`ifndef RISCV_CSR_REGISTER_FILE_MACROS_SVH
`define RISCV_CSR_REGISTER_FILE_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define RVCSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define RVCSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/rvcsr_pkg.sv -----
// Types and constants of the RV32 CSR file.
package rvcsr_pkg;

    localparam int NUM_STORE = 20;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        ACT_READ,
        ACT_WRITE,
        ACT_ADD_CYCLE,
        ACT_ADD_INSTRET
    } t_action;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_STORE,
        SEL_MISA,
        SEL_CYCLE,
        SEL_INSTRET,
        SEL_SSTATUS,
        SEL_SIE,
        SEL_SIP
    } t_csr_kind;

    typedef logic [4:0] t_store_idx;

    typedef struct packed {
        t_csr_kind  kind;
        t_store_idx idx;
    } t_csr_sel;

    localparam logic [11:0] ADDR_MISA    = 12'h301;
    localparam logic [11:0] ADDR_CYCLE   = 12'hB00;
    localparam logic [11:0] ADDR_INSTRET = 12'hB02;
    localparam logic [11:0] ADDR_SSTATUS = 12'h100;
    localparam logic [11:0] ADDR_SIE     = 12'h104;
    localparam logic [11:0] ADDR_SIP     = 12'h144;

    // Addresses of the plain storage registers, in storage order.
    localparam logic [11:0] STORE_ADDR [NUM_STORE] = '{
        12'h300, 12'h305, 12'h340, 12'h341, 12'h342, 12'h343, 12'h304, 12'h344,
        12'h3A0, 12'h3B0, 12'hF14, 12'hF11, 12'hF12, 12'hF13,
        12'h105, 12'h141, 12'h142, 12'h143, 12'h302, 12'h303
    };

    localparam t_store_idx IDX_MSTATUS = 5'd0;
    localparam t_store_idx IDX_MIE     = 5'd6;
    localparam t_store_idx IDX_MIP     = 5'd7;

    localparam logic [31:0] MISA_VALUE       = 32'h4000_1101;
    localparam logic [31:0] SSTATUS_WIN_BITS = 32'h0000_0122;
    localparam logic [31:0] SINT_MASK        = 32'h0000_0222;

endpackage

// ----- hw/rtl/riscv_csr_register_file.sv -----
// Top level of the reduced RV32 machine and supervisor CSR file.
//
// Requests arrive on the s_axis channel: tuser carries the action (read,
// write, add to the cycle counter, add to the retired-instruction counter),
// tdata carries the CSR address, the write value and the 64-bit counter delta.
// Each request yields exactly one response on the m_axis channel: tdata holds
// the read data (zero for anything but a read) and tuser[0] says whether the
// address is implemented or the action was a counter add.
// A request is captured in an input register, decoded and executed against
// the CSR state once the output register is free, and the response is
// registered in that output register. One request is taken every cycle
// while the output side keeps up; the rate is set by the single
// decode-and-update pass between the two registers.
// When the receiver stalls, the response is held stable and the input register
// fills; s_axis_tready drops only while both registers are occupied.
// A synchronous reset clears all storage CSRs and both 64-bit counters to zero and
// empties both registers.
module riscv_csr_register_file (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // csr_address [11:0], write_value [43:12], count_delta [107:44], zero [111:108]
    input  logic [rvcsr_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // action [1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data [31:0]
    output logic [rvcsr_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // accepted [0]
    output logic [0:0]                          m_axis_tuser
);
    import rvcsr_pkg::*;

    logic        r_in_valid;
    t_action     r_in_action;
    logic [11:0] r_in_addr;
    logic [31:0] r_in_wval;
    logic [63:0] r_in_delta;

    logic        r_out_valid;
    logic [31:0] r_out_rdata;
    logic        r_out_ok;

    logic        out_free;
    logic        advance;
    logic        s_accept;
    t_csr_sel    sel;
    logic [31:0] ex_rdata;
    logic        ex_ok;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_action <= t_action'(s_axis_tuser);
            r_in_addr   <= s_axis_tdata[11:0];
            r_in_wval   <= s_axis_tdata[43:12];
            r_in_delta  <= s_axis_tdata[107:44];
        end
    end

    rvcsr_decode u_decode (
        .i_addr (r_in_addr),
        .o_sel  (sel)
    );

    rvcsr_exec u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_action (r_in_action),
        .i_sel    (sel),
        .i_wval   (r_in_wval),
        .i_delta  (r_in_delta),
        .o_rdata  (ex_rdata),
        .o_ok     (ex_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_rdata <= ex_rdata;
            r_out_ok    <= ex_ok;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_rdata;
    assign m_axis_tuser[0] = r_out_ok;

endmodule

// ----- hw/rtl/rvcsr_decode.sv -----
// Address decoder: maps a 12-bit CSR address to a register kind and storage slot.
module rvcsr_decode (
    input  logic [11:0]         i_addr,
    output rvcsr_pkg::t_csr_sel o_sel
);
    import rvcsr_pkg::*;

    always_comb begin
        o_sel.kind = SEL_NONE;
        o_sel.idx  = '0;
        for (int i = 0; i < NUM_STORE; i++) begin
            if (i_addr == STORE_ADDR[i]) begin
                o_sel.kind = SEL_STORE;
                o_sel.idx  = t_store_idx'(i);
            end
        end
        case (i_addr)
            ADDR_MISA:    o_sel.kind = SEL_MISA;
            ADDR_CYCLE:   o_sel.kind = SEL_CYCLE;
            ADDR_INSTRET: o_sel.kind = SEL_INSTRET;
            ADDR_SSTATUS: o_sel.kind = SEL_SSTATUS;
            ADDR_SIE:     o_sel.kind = SEL_SIE;
            ADDR_SIP:     o_sel.kind = SEL_SIP;
            default: ;
        endcase
    end

endmodule

// ----- hw/rtl/rvcsr_exec.sv -----
// CSR state and the read, write and counter-add logic for one request.
module rvcsr_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  rvcsr_pkg::t_action  i_action,
    input  rvcsr_pkg::t_csr_sel i_sel,
    input  logic [31:0]         i_wval,
    input  logic [63:0]         i_delta,
    output logic [31:0]         o_rdata,
    output logic                o_ok
);
    import rvcsr_pkg::*;

    logic [31:0] r_store [NUM_STORE];
    logic [31:0] n_store [NUM_STORE];
    logic [63:0] r_cycle;
    logic [63:0] n_cycle;
    logic [63:0] r_instret;
    logic [63:0] n_instret;

    always_comb begin
        n_store   = r_store;
        n_cycle   = r_cycle;
        n_instret = r_instret;
        o_rdata   = '0;
        o_ok      = 1'b0;
        case (i_action)
            ACT_READ: begin
                o_ok = (i_sel.kind != SEL_NONE);
                case (i_sel.kind)
                    SEL_STORE:   o_rdata = r_store[i_sel.idx];
                    SEL_MISA:    o_rdata = MISA_VALUE;
                    SEL_CYCLE:   o_rdata = r_cycle[31:0];
                    SEL_INSTRET: o_rdata = r_instret[31:0];
                    SEL_SSTATUS: o_rdata = r_store[IDX_MSTATUS] & SSTATUS_WIN_BITS;
                    SEL_SIE:     o_rdata = r_store[IDX_MIE] & SINT_MASK;
                    SEL_SIP:     o_rdata = r_store[IDX_MIP] & SINT_MASK;
                    default:     o_rdata = '0;
                endcase
            end
            ACT_WRITE: begin
                o_ok = (i_sel.kind != SEL_NONE);
                case (i_sel.kind)
                    SEL_STORE:   n_store[i_sel.idx] = i_wval;
                    SEL_CYCLE:   n_cycle = {r_cycle[63:32], i_wval};
                    SEL_INSTRET: n_instret = {r_instret[63:32], i_wval};
                    SEL_SSTATUS: begin
                        n_store[IDX_MSTATUS] = (r_store[IDX_MSTATUS] & ~SSTATUS_WIN_BITS)
                                             | (i_wval & SSTATUS_WIN_BITS);
                    end
                    SEL_SIE: begin
                        n_store[IDX_MIE] = (r_store[IDX_MIE] & ~SINT_MASK)
                                         | (i_wval & SINT_MASK);
                    end
                    SEL_SIP: begin
                        n_store[IDX_MIP] = (r_store[IDX_MIP] & ~SINT_MASK)
                                         | (i_wval & SINT_MASK);
                    end
                    default: ;
                endcase
            end
            ACT_ADD_CYCLE: begin
                n_cycle = r_cycle + i_delta;
                o_ok    = 1'b1;
            end
            ACT_ADD_INSTRET: begin
                n_instret = r_instret + i_delta;
                o_ok      = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STORE; i++) begin
                r_store[i] <= '0;
            end
            r_cycle   <= '0;
            r_instret <= '0;
        end else if (i_en) begin
            r_store   <= n_store;
            r_cycle   <= n_cycle;
            r_instret <= n_instret;
        end
    end

endmodule

// ----- hw/rtl/rvcsr_checker.sv -----
// Port-level checker for the CSR file, bound to the top level.
`include "riscv_csr_register_file_macros.svh"

module rvcsr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rvcsr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                      m_axis_tuser
);

    // Reset empties the response register.
    `RVCSR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "response valid after reset")

    // A rejected request never carries read data.
    `RVCSR_ASSERT(a_reject_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0, "nonzero data on rejected request")

    // The request side never stalls while the response side drains.
    `RVCSR_ASSERT(a_no_stall_drain, i_clk, i_rst_n, m_axis_tready |-> s_axis_tready, "input stalled while output drains")

    // A stalled response holds.
    `RVCSR_ASSERT(a_hold_resp, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled response changed")

endmodule

bind riscv_csr_register_file rvcsr_checker u_rvcsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
